// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms, clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAE_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lae_pkg.sv
// ---------------------------------------------------------------------------
// lae_pkg
// Widths, codes, reset values and state encoding of the life automaton engine.
// ---------------------------------------------------------------------------
package lae_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int ACTION_W    = 2;
  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;
  localparam int GEN_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DIM_W-1:0] ROWS_RST = 7'd64;
  localparam logic [DIM_W-1:0] COLS_RST = 7'd64;
  localparam logic [GEN_W-1:0] GENS_RST = 16'd1000;

  // B3/S23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_RUN   = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_GENS = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_ACC,
    S_GEN,
    S_FIN
  } state_t;

endpackage

// File: design/lae_if.sv
// ---------------------------------------------------------------------------
// lae_if
// Valid/ready channels of the life automaton engine: command, result, config.
// ---------------------------------------------------------------------------
interface lae_in_if;
  logic                            valid;
  logic                            ready;
  logic [lae_pkg::ACTION_W-1:0]    action;
  logic [lae_pkg::COORD_W-1:0]     row;
  logic [lae_pkg::COORD_W-1:0]     col;
  logic                            cell_value;

  modport source (output valid, action, row, col, cell_value, input ready);
  modport sink   (input valid, action, row, col, cell_value, output ready);
endinterface

interface lae_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic status;
  logic run_done;

  modport source (output valid, cell_alive, status, run_done, input ready);
  modport sink   (input valid, cell_alive, status, run_done, output ready);
endinterface

interface lae_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lae_pkg::CFG_INDEX_W-1:0]   index;
  logic [lae_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/life_automaton_engine.sv
// ---------------------------------------------------------------------------
// life_automaton_engine
// B3/S23 cellular automaton on a bordered grid with cell access and run command.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one command per transfer - write cell, read cell or run.
//   out_ch : one result per command (cell_alive, status, run_done).
//   cfg_ch : register writes (rows, columns, generations), always ready; write
//            only while no command is outstanding.
// Sequence: write/read go through S_RD, S_ACC and S_FIN to out valid; out-of-range
//   or unknown command goes straight to S_FIN. A run reads one grid row per cycle
//   through the row update unit on the single memory read port, generation by
//   generation; it stops early once a generation leaves the grid unchanged.
// Throughput: one command at a time; in_ready is high only while idle.
// Reset: the live bank is cleared one row per cycle with in_ready low; config
//   registers take their reset values.
// Stall: a finished result sits in the output register; the next command is
//   taken meanwhile, its own result waits until that register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module life_automaton_engine #(
  parameter int MAX_ROWS = lae_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lae_pkg::MAX_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lae_in_if.sink        in_ch,
  lae_out_if.source     out_ch,
  lae_cfg_if.sink       cfg_ch
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int AW   = RW + 1;
  localparam int SW   = $clog2(MAX_ROWS + 2);
  localparam int RCW  = (SW > lae_pkg::DIM_W) ? SW : lae_pkg::DIM_W;
  localparam int CCW0 = $clog2(MAX_COLS + 1);
  localparam int CCW  = (CCW0 > lae_pkg::DIM_W) ? CCW0 : lae_pkg::DIM_W;
  localparam int XW   = (RW > lae_pkg::COORD_W) ? RW : lae_pkg::COORD_W;

  lae_pkg::state_t state_r, state_nxt;

  logic [lae_pkg::DIM_W-1:0]   rows_r;
  logic [lae_pkg::DIM_W-1:0]   cols_r;
  logic [lae_pkg::GEN_W-1:0]   gens_r;
  logic [RCW-1:0]              nr;
  logic [CCW-1:0]              nc;
  logic [MAX_COLS-1:0]         colmask;

  logic [lae_pkg::COORD_W-1:0] row_r;
  logic [lae_pkg::COORD_W-1:0] col_r;
  logic                        val_r;
  logic                        wr_cell_r;
  logic                        res_alive_r;
  logic                        res_status_r;
  logic                        res_done_r;

  logic                        out_valid_r;
  logic                        out_alive_r;
  logic                        out_status_r;
  logic                        out_done_r;

  logic                        bank_r;
  logic [SW-1:0]               step_r;
  logic                        rd_vld_r;
  logic [SW-1:0]               rd_idx_r;
  logic [MAX_COLS-1:0]         above_r;
  logic [MAX_COLS-1:0]         mid_r;
  logic [MAX_COLS-1:0]         mid_raw_r;
  logic                        wr_vld_r;
  logic [RW-1:0]               wr_idx_r;
  logic [MAX_COLS-1:0]         wr_row_r;
  logic                        chg_r;
  logic [lae_pkg::GEN_W-1:0]   gen_cnt_r;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [MAX_COLS-1:0]         mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [MAX_COLS-1:0]         mem_rdata;

  logic                        in_ready;
  logic                        in_fire;
  logic                        in_range;
  logic                        run_skip;
  logic                        slot_free;
  logic                        gen_last;
  logic                        mid_in_area;
  logic [XW-1:0]               row_x;
  logic [RW-1:0]               cell_addr;
  logic                        cell_bit;
  logic [MAX_COLS-1:0]         cell_wdata;
  logic [MAX_COLS-1:0]         new_row;
  logic [MAX_COLS-1:0]         nxt_row;
  logic [MAX_COLS-1:0]         nxt_masked;
  logic [SW-1:0]               mid_idx;

  // Effective area, saturated to the array size
  assign nr = (RCW'(rows_r) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_r);
  assign nc = (CCW'(cols_r) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_r);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = CCW'(c) < nc;
    end
  end

  assign in_fire   = in_ch.valid && in_ready;
  assign in_range  = (RCW'(in_ch.row) < nr) && (CCW'(in_ch.col) < nc);
  assign run_skip  = (gens_r == '0) || (nr == '0) || (nc == '0);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign gen_last  = wr_vld_r && (wr_idx_r == RW'(MAX_ROWS - 1));

  assign row_x     = XW'(row_r);
  assign cell_addr = row_x[RW-1:0];

  always_comb begin
    cell_bit = 1'b0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cell_wdata[c] = (CCW'(col_r) == CCW'(c)) ? val_r : mem_rdata[c];
      cell_bit      = cell_bit | ((CCW'(col_r) == CCW'(c)) & mem_rdata[c]);
    end
  end

  // Row sweep: the row arriving now is the lower neighbour of mid_r
  assign new_row     = (rd_vld_r && (RCW'(rd_idx_r) < nr)) ? (mem_rdata & colmask) : '0;
  assign mid_in_area = RCW'(rd_idx_r) <= nr;
  assign nxt_masked  = mid_in_area ? nxt_row : '0;
  assign mid_idx     = rd_idx_r - SW'(1);

  lae_row_unit #(
    .COLS (MAX_COLS)
  ) u_row (
    .above   (above_r),
    .mid     (mid_r),
    .below   (new_row),
    .colmask (colmask),
    .nxt     (nxt_row)
  );

  lae_grid_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lae_pkg::S_CLEAR: begin
        if (step_r == SW'(MAX_ROWS - 1)) begin
          state_nxt = lae_pkg::S_IDLE;
        end
      end
      lae_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.action) inside
            lae_pkg::ACT_WRITE, lae_pkg::ACT_READ: begin
              state_nxt = in_range ? lae_pkg::S_RD : lae_pkg::S_FIN;
            end
            lae_pkg::ACT_RUN: begin
              state_nxt = run_skip ? lae_pkg::S_FIN : lae_pkg::S_GEN;
            end
            default: begin
              state_nxt = lae_pkg::S_FIN;
            end
          endcase
        end
      end
      lae_pkg::S_RD: begin
        state_nxt = lae_pkg::S_ACC;
      end
      lae_pkg::S_ACC: begin
        state_nxt = lae_pkg::S_FIN;
      end
      lae_pkg::S_GEN: begin
        if (gen_last && ((gen_cnt_r == lae_pkg::GEN_W'(1)) || !chg_r)) begin
          state_nxt = lae_pkg::S_FIN;
        end
      end
      lae_pkg::S_FIN: begin
        if (slot_free) begin
          state_nxt = lae_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lae_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {bank_r, cell_addr};
    mem_wdata = cell_wdata;
    mem_raddr = {bank_r, cell_addr};
    unique case (state_r)
      lae_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, step_r[RW-1:0]};
        mem_wdata = '0;
      end
      lae_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      lae_pkg::S_RD: begin
      end
      lae_pkg::S_ACC: begin
        mem_we = wr_cell_r;
      end
      lae_pkg::S_GEN: begin
        mem_raddr = {bank_r, (step_r < SW'(MAX_ROWS)) ? step_r[RW-1:0] : RW'(0)};
        mem_we    = wr_vld_r;
        mem_waddr = {~bank_r, wr_idx_r};
        mem_wdata = wr_row_r;
      end
      lae_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lae_pkg::S_CLEAR;
      step_r      <= '0;
      bank_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= lae_pkg::ROWS_RST;
      cols_r      <= lae_pkg::COLS_RST;
      gens_r      <= lae_pkg::GENS_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          lae_pkg::CFG_ROWS: rows_r <= cfg_ch.data[lae_pkg::DIM_W-1:0];
          lae_pkg::CFG_COLS: cols_r <= cfg_ch.data[lae_pkg::DIM_W-1:0];
          lae_pkg::CFG_GENS: gens_r <= cfg_ch.data[lae_pkg::GEN_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == lae_pkg::S_CLEAR) begin
        step_r <= step_r + SW'(1);
      end else if (state_r == lae_pkg::S_IDLE) begin
        step_r <= '0;
      end else if (state_r == lae_pkg::S_GEN) begin
        if (gen_last) begin
          step_r <= '0;
        end else if (step_r <= SW'(MAX_ROWS)) begin
          step_r <= step_r + SW'(1);
        end
      end

      rd_vld_r <= (state_r == lae_pkg::S_GEN) && (step_r <= SW'(MAX_ROWS));
      wr_vld_r <= (state_r == lae_pkg::S_GEN) && rd_vld_r && (rd_idx_r != '0);

      if ((state_r == lae_pkg::S_GEN) && gen_last) begin
        bank_r <= ~bank_r;
      end

      if ((state_r == lae_pkg::S_FIN) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= step_r;

    if (in_fire) begin
      row_r        <= in_ch.row;
      col_r        <= in_ch.col;
      val_r        <= in_ch.cell_value;
      wr_cell_r    <= in_ch.action == lae_pkg::ACT_WRITE;
      res_alive_r  <= 1'b0;
      res_status_r <= ((in_ch.action == lae_pkg::ACT_WRITE)
                    || (in_ch.action == lae_pkg::ACT_READ)) && !in_range;
      res_done_r   <= in_ch.action == lae_pkg::ACT_RUN;
      gen_cnt_r    <= gens_r;
      above_r      <= '0;
      mid_r        <= '0;
      chg_r        <= 1'b0;
    end

    if (state_r == lae_pkg::S_ACC) begin
      res_alive_r <= !wr_cell_r && cell_bit;
    end

    if (state_r == lae_pkg::S_GEN) begin
      if (gen_last) begin
        gen_cnt_r <= gen_cnt_r - lae_pkg::GEN_W'(1);
        above_r   <= '0;
        mid_r     <= '0;
        chg_r     <= 1'b0;
      end else if (rd_vld_r) begin
        above_r   <= mid_r;
        mid_r     <= new_row;
        mid_raw_r <= mem_rdata;
        wr_idx_r  <= mid_idx[RW-1:0];
        wr_row_r  <= nxt_masked;
        if (rd_idx_r != '0) begin
          chg_r <= chg_r | (nxt_masked != mid_raw_r);
        end
      end
    end

    if ((state_r == lae_pkg::S_FIN) && slot_free) begin
      out_alive_r  <= res_alive_r;
      out_status_r <= res_status_r;
      out_done_r   <= res_done_r;
    end
  end

  assign in_ch.ready       = in_ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_alive = out_alive_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.run_done   = out_done_r;

  `LAE_CHECK_NOW(a_gen_scratch_bank, (state_r == lae_pkg::S_GEN) && mem_we, mem_waddr[RW] != bank_r, "generation write hit the live bank")
  `LAE_CHECK_NEXT(a_busy_after_accept, in_fire, !in_ch.ready, "command taken while busy")
  `LAE_CHECK_NEXT(a_result_from_fin, !out_valid_r && (state_r != lae_pkg::S_FIN), !out_valid_r, "result raised outside finish")
  `LAE_CHECK_NOW(a_row_write_in_gen, wr_vld_r, state_r == lae_pkg::S_GEN, "row write pending outside a run")

endmodule

// File: design/lae_grid_mem.sv
// ---------------------------------------------------------------------------
// lae_grid_mem
// Two-bank row store of the cell grid, one write and one registered read port.
// ---------------------------------------------------------------------------
module lae_grid_mem #(
  parameter int ROWS = lae_pkg::MAX_ROWS_DEF,
  parameter int COLS = lae_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ROWS):0]      waddr,
  input  logic [COLS-1:0]            wdata,
  input  logic [$clog2(ROWS):0]      raddr,
  output logic [COLS-1:0]            rdata
);

  localparam int AW    = $clog2(ROWS) + 1;
  localparam int DEPTH = 2 ** AW;

  logic [COLS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_q[raddr];
  end

endmodule

// File: design/lae_row_unit.sv
// ---------------------------------------------------------------------------
// lae_row_unit
// Next state of one grid row from the rows above and below, B3/S23 rule.
// ---------------------------------------------------------------------------
module lae_row_unit #(
  parameter int COLS = lae_pkg::MAX_COLS_DEF
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] mid,
  input  logic [COLS-1:0] below,
  input  logic [COLS-1:0] colmask,
  output logic [COLS-1:0] nxt
);

  logic [COLS+1:0] a_pad;
  logic [COLS+1:0] m_pad;
  logic [COLS+1:0] b_pad;

  assign a_pad = {1'b0, above, 1'b0};
  assign m_pad = {1'b0, mid, 1'b0};
  assign b_pad = {1'b0, below, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic [3:0] cnt;
    logic       alive;

    assign cnt = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
               + 4'(m_pad[c]) + 4'(m_pad[c+2])
               + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);

    assign alive = (cnt == lae_pkg::BIRTH_COUNT)
                || (mid[c] && (cnt == lae_pkg::SURVIVE_COUNT));

    assign nxt[c] = alive && colmask[c];
  end

endmodule
